/* src/sbmq_pkg.sv */
// sbmq_pkg: shared types, codes and state encoding for the shared buffer queue manager
// no dependencies
package sbmq_pkg;

    localparam int NUM_QUEUES   = 65;
    localparam int QIDX_W       = 7;
    localparam int MAX_OUT      = 64;

    localparam logic [1:0] OP_ARRIVAL = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_REPORT  = 2'd2;

    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [1:0] PORT_PERIODIC = 2'd0;
    localparam logic [1:0] PORT_CRITICAL = 2'd1;
    localparam logic [1:0] PORT_BURST    = 2'd2;

    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_BUF_FULL   = 3'd1;
    localparam logic [2:0] ST_BURST_FULL = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
    localparam logic [2:0] ST_BAD_STREAM = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  stream;
        logic [5:0]  destination;
        logic [15:0] pkt_size;
        logic [15:0] pkt_tag;
        logic [31:0] now;
        logic [6:0]  subqueue;
        logic [6:0]  frame_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] out_tag;
        logic [15:0] out_size;
        logic [1:0]  out_port;
        logic [2:0]  status;
        logic [6:0]  queue_index;
        logic [6:0]  queue_count;
        logic [31:0] head_age;
        logic [31:0] buffered_bits;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARR_CHECK,
        S_ARR_WRITE,
        S_DEQ_PTR,
        S_DEQ_READ,
        S_DEQ_WAIT,
        S_DEQ_EMIT,
        S_RPT_PTR,
        S_RPT_READ,
        S_RPT_WAIT,
        S_RPT_LOAD,
        S_RPT_SCAN,
        S_RPT_EMIT,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;      // capture input transaction, compute route
        logic ptr_read;      // read pointers and fill of the latched queue
        logic arr_write;     // admit / drop, write store, emit status
        logic deq_read;      // issue store read at head of dequeue queue
        logic deq_emit;      // pop and build packet result
        logic rpt_start;     // reset report walk counter, used flags and emitted count
        logic rpt_ptr;       // read pointers and fill of report queue counter
        logic rpt_read;      // issue store read for report queue counter
        logic rpt_load;      // store age and fill for report queue counter, advance
        logic scan_start;    // start a selection pass
        logic scan_step;     // compare one candidate
        logic rpt_emit;      // emit the selected report entry
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic deq_ok;        // dequeue queue valid and nonempty, under limit
        logic walk_done;     // report load walk finished
        logic scan_done;     // selection pass finished
    } status_t;

endpackage

/* src/sbmq_ctrl.sv */
// sbmq_ctrl: sequencing state machine for arrivals, dequeues and reports
// depends on sbmq_pkg
module sbmq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          in_op,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic                out_last,
    output sbmq_pkg::cmd_t      cmd,
    input  sbmq_pkg::status_t   stat
);

    sbmq_pkg::state_t state_reg, state_next;
    sbmq_pkg::state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbmq_pkg::S_IDLE;
            ret_reg   <= sbmq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            sbmq_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    case (in_op)
                        sbmq_pkg::OP_ARRIVAL: state_next = sbmq_pkg::S_ARR_CHECK;
                        sbmq_pkg::OP_DEQUEUE: state_next = sbmq_pkg::S_DEQ_PTR;
                        sbmq_pkg::OP_REPORT:
                        begin
                            cmd.rpt_start = 1'b1;
                            state_next = sbmq_pkg::S_RPT_PTR;
                        end
                        default: state_next = sbmq_pkg::S_IDLE;
                    endcase
                end
            end
            sbmq_pkg::S_ARR_CHECK:
            begin
                cmd.ptr_read = 1'b1;
                state_next = sbmq_pkg::S_ARR_WRITE;
            end
            sbmq_pkg::S_ARR_WRITE:
            begin
                cmd.arr_write = 1'b1;
                ret_next = sbmq_pkg::S_IDLE;
                state_next = sbmq_pkg::S_OUT;
            end
            sbmq_pkg::S_DEQ_PTR:
            begin
                cmd.ptr_read = 1'b1;
                state_next = sbmq_pkg::S_DEQ_READ;
            end
            sbmq_pkg::S_DEQ_READ:
            begin
                if (stat.deq_ok)
                begin
                    cmd.deq_read = 1'b1;
                    state_next = sbmq_pkg::S_DEQ_WAIT;
                end
                else
                    state_next = sbmq_pkg::S_IDLE;
            end
            sbmq_pkg::S_DEQ_WAIT:
            begin
                state_next = sbmq_pkg::S_DEQ_EMIT;
            end
            sbmq_pkg::S_DEQ_EMIT:
            begin
                cmd.deq_emit = 1'b1;
                ret_next = sbmq_pkg::S_DEQ_READ;
                state_next = sbmq_pkg::S_OUT;
            end
            sbmq_pkg::S_RPT_PTR:
            begin
                cmd.rpt_ptr = 1'b1;
                state_next = sbmq_pkg::S_RPT_READ;
            end
            sbmq_pkg::S_RPT_READ:
            begin
                cmd.rpt_read = 1'b1;
                state_next = sbmq_pkg::S_RPT_WAIT;
            end
            sbmq_pkg::S_RPT_WAIT:
            begin
                state_next = sbmq_pkg::S_RPT_LOAD;
            end
            sbmq_pkg::S_RPT_LOAD:
            begin
                cmd.rpt_load = 1'b1;
                if (stat.walk_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = sbmq_pkg::S_RPT_SCAN;
                end
                else
                    state_next = sbmq_pkg::S_RPT_PTR;
            end
            sbmq_pkg::S_RPT_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = sbmq_pkg::S_RPT_EMIT;
            end
            sbmq_pkg::S_RPT_EMIT:
            begin
                cmd.rpt_emit = 1'b1;
                ret_next = sbmq_pkg::S_RPT_SCAN;
                state_next = sbmq_pkg::S_OUT;
            end
            sbmq_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (out_last)
                        state_next = sbmq_pkg::S_IDLE;
                    else
                    begin
                        state_next = ret_reg;
                        if (ret_reg == sbmq_pkg::S_RPT_SCAN)
                            cmd.scan_start = 1'b1;
                    end
                end
            end
            default: state_next = sbmq_pkg::S_IDLE;
        endcase
    end

endmodule

/* src/sbmq_datapath.sv */
// sbmq_datapath: descriptor store, queue pointer store, admission and report selection
// depends on sbmq_pkg
module sbmq_datapath #(
    parameter int QUEUE_DEPTH   = 64,
    parameter int REPORT_QUEUES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sbmq_pkg::in_item_t  in_item,
    input  logic [31:0]         limit,
    input  sbmq_pkg::cmd_t      cmd,
    output sbmq_pkg::status_t   stat,
    output sbmq_pkg::out_item_t out_item
);

    localparam int NQ     = sbmq_pkg::NUM_QUEUES;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QS_W   = 2 * PTR_W + FILL_W;
    localparam int QW     = sbmq_pkg::QIDX_W;
    localparam int ADDR_W = $clog2(NQ * QUEUE_DEPTH);
    localparam int RW     = (REPORT_QUEUES > 1) ? $clog2(REPORT_QUEUES) : 1;
    localparam int RC_W   = $clog2(REPORT_QUEUES + 1);
    localparam int FC_W   = 7;

    logic [63:0] mem [NQ * QUEUE_DEPTH];
    logic [63:0] rd_data_reg;

    // per queue head, tail and fill; an entry never written reads as zero
    logic [QS_W-1:0]   qstate [NQ];
    logic [NQ-1:0]     qv_reg;
    logic [PTR_W-1:0]  cur_head_reg;
    logic [PTR_W-1:0]  cur_tail_reg;
    logic [FILL_W-1:0] cur_fill_reg;
    logic [31:0]       total_reg;

    sbmq_pkg::in_item_t in_reg;
    logic [QW-1:0]      q_reg;
    logic               bad_reg;
    logic               burst_reg;
    logic               over_reg;
    logic [FC_W-1:0]    cnt_reg;
    logic [FC_W-1:0]    lim_reg;
    logic [1:0]         port_reg;

    logic [31:0]        age_reg  [REPORT_QUEUES];
    logic [FILL_W-1:0]  rfill_reg [REPORT_QUEUES];
    logic [REPORT_QUEUES-1:0] used_reg;
    logic [RC_W-1:0]    walk_reg;
    logic [RC_W-1:0]    scan_reg;
    logic [RC_W-1:0]    emitted_reg;
    logic [RW-1:0]      best_reg;
    logic               have_reg;

    sbmq_pkg::out_item_t out_reg;

    logic [QW-1:0] rq;
    logic [QW-1:0] aq;
    logic          abad;
    logic          aburst;
    logic [31:0]   dsize;
    logic [31:0]   age_now;
    logic          arr_ok;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  tail_inc;
    logic              qs_we;
    logic [QS_W-1:0]   qs_wdata;
    logic [QW-1:0]     ptr_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [RW-1:0]     walk_idx;
    logic [RW-1:0]     scan_idx;

    assign walk_idx = walk_reg[RW-1:0];
    assign scan_idx = scan_reg[RW-1:0];
    assign rq       = QW'(32 + int'(walk_idx));
    assign ptr_addr = cmd.rpt_ptr ? rq : q_reg;
    assign wr_addr  = ADDR_W'(int'(q_reg) * QUEUE_DEPTH + int'(cur_tail_reg));
    assign rd_addr  = cmd.rpt_read
                      ? ADDR_W'(int'(rq) * QUEUE_DEPTH + int'(cur_head_reg))
                      : ADDR_W'(int'(q_reg) * QUEUE_DEPTH + int'(cur_head_reg));
    assign dsize    = {16'd0, rd_data_reg[63:48]};
    assign age_now  = in_reg.now - rd_data_reg[31:0];
    assign arr_ok   = cmd.arr_write && !bad_reg && !over_reg
                      && (cur_fill_reg < FILL_W'(QUEUE_DEPTH));
    assign head_inc = (int'(cur_head_reg) == QUEUE_DEPTH - 1) ? '0 : cur_head_reg + 1'b1;
    assign tail_inc = (int'(cur_tail_reg) == QUEUE_DEPTH - 1) ? '0 : cur_tail_reg + 1'b1;

    always_comb
    begin
        qs_we    = 1'b0;
        qs_wdata = {cur_head_reg, cur_tail_reg, cur_fill_reg};
        if (arr_ok)
        begin
            qs_we    = 1'b1;
            qs_wdata = {cur_head_reg, tail_inc, FILL_W'(cur_fill_reg + 1'b1)};
        end
        else if (cmd.deq_emit)
        begin
            qs_we    = 1'b1;
            qs_wdata = {head_inc, cur_tail_reg, FILL_W'(cur_fill_reg - 1'b1)};
        end
    end

    always_comb
    begin
        aq     = '0;
        abad   = 1'b0;
        aburst = (in_item.stream >= 7'd33) && (in_item.stream <= 7'd64);
        if (in_item.stream >= 7'd1 && in_item.stream <= 7'd32)
            aq = in_item.stream - 7'd1;
        else if (in_item.stream == 7'd0 || aburst)
        begin
            if (in_item.destination < 6'd1 || in_item.destination > 6'd32)
                abad = 1'b1;
            else
                aq = {1'b0, in_item.destination} + 7'd31;
        end
        else if (in_item.stream == 7'd65)
            aq = 7'd64;
        else
            abad = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (arr_ok)
            mem[wr_addr] <= {in_reg.pkt_size, in_reg.pkt_tag, in_reg.now};
        if (cmd.deq_read || cmd.rpt_read)
            rd_data_reg <= mem[rd_addr];
        if (qs_we)
            qstate[q_reg] <= qs_wdata;
        if (cmd.ptr_read || cmd.rpt_ptr)
        begin
            if (ptr_addr <= QW'(NQ - 1) && qv_reg[ptr_addr])
                {cur_head_reg, cur_tail_reg, cur_fill_reg} <= qstate[ptr_addr];
            else
                {cur_head_reg, cur_tail_reg, cur_fill_reg} <= '0;
        end
        else if (cmd.deq_emit)
        begin
            cur_head_reg <= head_inc;
            cur_fill_reg <= cur_fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg      <= '0;
            total_reg   <= '0;
            used_reg    <= '0;
            walk_reg    <= '0;
            scan_reg    <= '0;
            emitted_reg <= '0;
            best_reg    <= '0;
            have_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.latch_in)
                cnt_reg <= '0;
            if (qs_we)
                qv_reg[q_reg] <= 1'b1;
            if (arr_ok)
                total_reg <= total_reg + {16'd0, in_reg.pkt_size};
            if (cmd.deq_emit)
            begin
                total_reg <= (total_reg >= dsize) ? total_reg - dsize : '0;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.rpt_start)
            begin
                walk_reg    <= '0;
                used_reg    <= '0;
                emitted_reg <= '0;
            end
            if (cmd.rpt_load)
                walk_reg <= walk_reg + 1'b1;
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
                have_reg <= 1'b0;
            end
            else if (cmd.scan_step && !stat.scan_done)
            begin
                if (!used_reg[scan_idx] &&
                    (!have_reg || age_reg[scan_idx] > age_reg[best_reg]))
                begin
                    best_reg <= scan_idx;
                    have_reg <= 1'b1;
                end
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.rpt_emit)
            begin
                used_reg[best_reg] <= 1'b1;
                emitted_reg <= emitted_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_reg    <= in_item;
            bad_reg   <= abad;
            burst_reg <= aburst;
            if (in_item.op == sbmq_pkg::OP_ARRIVAL)
                q_reg <= aq;
            else
                q_reg <= in_item.subqueue;
            if (in_item.subqueue < 7'd32)
            begin
                port_reg <= sbmq_pkg::PORT_PERIODIC;
                lim_reg  <= 7'd1;
            end
            else if (in_item.subqueue < 7'd64)
            begin
                port_reg <= sbmq_pkg::PORT_BURST;
                lim_reg  <= (in_item.frame_count > 7'd64) ? 7'd64 : in_item.frame_count;
            end
            else
            begin
                port_reg <= sbmq_pkg::PORT_CRITICAL;
                lim_reg  <= (in_item.subqueue == 7'd64) ? 7'd1 : 7'd0;
            end
        end
        if (cmd.latch_in)
            over_reg <= 1'b0;
        else
            over_reg <= ({1'b0, total_reg} + {17'd0, in_reg.pkt_size}) > {1'b0, limit};
        if (cmd.rpt_load)
        begin
            age_reg[walk_idx]   <= (cur_fill_reg != '0) ? age_now : 32'd0;
            rfill_reg[walk_idx] <= cur_fill_reg;
        end
        if (cmd.arr_write)
        begin
            out_reg.kind        <= sbmq_pkg::KIND_STATUS;
            out_reg.out_tag     <= '0;
            out_reg.out_size    <= '0;
            out_reg.out_port    <= sbmq_pkg::PORT_PERIODIC;
            out_reg.queue_count <= '0;
            out_reg.head_age    <= '0;
            out_reg.last        <= 1'b1;
            if (bad_reg)
            begin
                out_reg.status        <= sbmq_pkg::ST_BAD_STREAM;
                out_reg.queue_index   <= '0;
                out_reg.buffered_bits <= total_reg;
            end
            else
            begin
                out_reg.queue_index <= q_reg;
                if (over_reg)
                begin
                    out_reg.status <= burst_reg ? sbmq_pkg::ST_BURST_FULL
                                                : sbmq_pkg::ST_BUF_FULL;
                    out_reg.buffered_bits <= total_reg;
                end
                else if (cur_fill_reg >= FILL_W'(QUEUE_DEPTH))
                begin
                    out_reg.status        <= sbmq_pkg::ST_QUEUE_FULL;
                    out_reg.buffered_bits <= total_reg;
                end
                else
                begin
                    out_reg.status        <= sbmq_pkg::ST_ACCEPTED;
                    out_reg.buffered_bits <= total_reg + {16'd0, in_reg.pkt_size};
                end
            end
        end
        if (cmd.deq_emit)
        begin
            out_reg.kind          <= sbmq_pkg::KIND_PACKET;
            out_reg.out_tag       <= rd_data_reg[47:32];
            out_reg.out_size      <= rd_data_reg[63:48];
            out_reg.out_port      <= port_reg;
            out_reg.status        <= sbmq_pkg::ST_ACCEPTED;
            out_reg.queue_index   <= q_reg;
            out_reg.queue_count   <= 7'(cur_fill_reg - 1'b1);
            out_reg.head_age      <= age_now;
            out_reg.buffered_bits <= (total_reg >= dsize) ? total_reg - dsize : '0;
            out_reg.last          <= (cnt_reg + 1'b1 >= lim_reg)
                                     || (cur_fill_reg == FILL_W'(1));
        end
        if (cmd.rpt_emit)
        begin
            out_reg.kind          <= sbmq_pkg::KIND_REPORT;
            out_reg.out_tag       <= '0;
            out_reg.out_size      <= '0;
            out_reg.out_port      <= sbmq_pkg::PORT_PERIODIC;
            out_reg.status        <= sbmq_pkg::ST_ACCEPTED;
            out_reg.queue_index   <= QW'(32 + int'(best_reg));
            out_reg.queue_count   <= 7'(rfill_reg[best_reg]);
            out_reg.head_age      <= age_reg[best_reg];
            out_reg.buffered_bits <= total_reg;
            out_reg.last          <= (emitted_reg + 1'b1 == RC_W'(REPORT_QUEUES));
        end
    end

    assign stat.deq_ok    = (q_reg <= 7'd64) && (cnt_reg < lim_reg) && (cur_fill_reg != '0);
    assign stat.walk_done = (walk_reg == RC_W'(REPORT_QUEUES - 1));
    assign stat.scan_done = (scan_reg == RC_W'(REPORT_QUEUES));
    assign out_item       = out_reg;

endmodule

/* src/shared_buffer_multi_queue_manager_core.sv */
// shared_buffer_multi_queue_manager_core: top level of the shared buffer queue manager
// arrival: pointer check, store write with status, output; dequeue: pointer read, then
// per packet store read, wait, emit and output; report: per queue pointer, read,
// wait and load, then per sorted entry a scan pass, emit and output; output may stall
// rst_n async active low clears pointers, fills, total and sets limit to 1048576
// depends on sbmq_pkg, sbmq_ctrl, sbmq_datapath
module shared_buffer_multi_queue_manager_core #(
    parameter int QUEUE_DEPTH   = 64,
    parameter int REPORT_QUEUES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sbmq_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sbmq_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    logic [31:0]       limit_reg;
    sbmq_pkg::cmd_t    cmd;
    sbmq_pkg::status_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 32'd1048576;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    sbmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_op     (in_data.op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_last  (out_data.last),
        .cmd       (cmd),
        .stat      (stat)
    );

    sbmq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .REPORT_QUEUES (REPORT_QUEUES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .limit    (limit_reg),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_data)
    );

endmodule

/* tb/shared_buffer_multi_queue_manager_core_tb.sv */
// shared_buffer_multi_queue_manager_core_tb: self-checking bench for the shared buffer queue manager
// drives arrivals, dequeues and reports with random idling, predicts results in a scoreboard class
// depends on sbmq_pkg and shared_buffer_multi_queue_manager_core
`timescale 1ns / 100ps

module shared_buffer_multi_queue_manager_core_tb;

    localparam int DEPTH = 64;
    localparam int RPT_Q = 32;
    localparam int WATCHDOG_LIMIT = 200000;

    class queue_scoreboard;
        logic [15:0] sz_mem [sbmq_pkg::NUM_QUEUES][DEPTH];
        logic [15:0] tag_mem [sbmq_pkg::NUM_QUEUES][DEPTH];
        logic [31:0] arr_mem [sbmq_pkg::NUM_QUEUES][DEPTH];
        int unsigned head [sbmq_pkg::NUM_QUEUES];
        int unsigned tail [sbmq_pkg::NUM_QUEUES];
        int unsigned fill [sbmq_pkg::NUM_QUEUES];
        logic [31:0] held_bits;
        logic [31:0] limit_bits;
        sbmq_pkg::out_item_t pending [$];
        int errors;

        function new();
            foreach (fill[i])
            begin
                head[i] = 0;
                tail[i] = 0;
                fill[i] = 0;
            end
            held_bits = 0;
            limit_bits = 32'd1048576;
            errors = 0;
        endfunction

        function void push_result(logic [1:0] kind, logic [15:0] tg, logic [15:0] sz,
                                   logic [1:0] port, logic [2:0] st, int qi, int cnt,
                                   logic [31:0] age);
            sbmq_pkg::out_item_t r;
            r.kind = kind;
            r.out_tag = tg;
            r.out_size = sz;
            r.out_port = port;
            r.status = st;
            r.queue_index = qi[6:0];
            r.queue_count = cnt[6:0];
            r.head_age = age;
            r.buffered_bits = held_bits;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void note_input(sbmq_pkg::in_item_t it);
            int q;
            int lim;
            int n;
            int best;
            logic [2:0] st;
            logic [1:0] port;
            logic [31:0] ages [RPT_Q];
            bit taken [RPT_Q];
            bit burst;
            int first;
            first = pending.size();
            n = 0;
            case (it.op)
                sbmq_pkg::OP_ARRIVAL:
                begin
                    burst = it.stream >= 33 && it.stream <= 64;
                    q = -1;
                    if (it.stream >= 1 && it.stream <= 32)
                        q = it.stream - 1;
                    else if ((it.stream == 0 || burst) && it.destination >= 1
                             && it.destination <= 32)
                        q = it.destination + 31;
                    else if (it.stream == 65)
                        q = 64;
                    if (q < 0)
                    begin
                        push_result(sbmq_pkg::KIND_STATUS, 16'd0, 16'd0,
                                    sbmq_pkg::PORT_PERIODIC, sbmq_pkg::ST_BAD_STREAM,
                                    0, 0, 32'd0);
                    end
                    else
                    begin
                        if ({1'b0, held_bits} + it.pkt_size > {1'b0, limit_bits})
                            st = burst ? sbmq_pkg::ST_BURST_FULL : sbmq_pkg::ST_BUF_FULL;
                        else if (fill[q] >= DEPTH)
                            st = sbmq_pkg::ST_QUEUE_FULL;
                        else
                        begin
                            sz_mem[q][tail[q]] = it.pkt_size;
                            tag_mem[q][tail[q]] = it.pkt_tag;
                            arr_mem[q][tail[q]] = it.now;
                            tail[q] = (tail[q] + 1) % DEPTH;
                            fill[q]++;
                            held_bits = held_bits + it.pkt_size;
                            st = sbmq_pkg::ST_ACCEPTED;
                        end
                        push_result(sbmq_pkg::KIND_STATUS, 16'd0, 16'd0,
                                    sbmq_pkg::PORT_PERIODIC, st, q, 0, 32'd0);
                    end
                    n = 1;
                end
                sbmq_pkg::OP_DEQUEUE:
                begin
                    q = it.subqueue;
                    lim = 0;
                    if (q < 32)
                    begin
                        port = sbmq_pkg::PORT_PERIODIC;
                        lim = 1;
                    end
                    else if (q < 64)
                    begin
                        port = sbmq_pkg::PORT_BURST;
                        lim = it.frame_count > sbmq_pkg::MAX_OUT
                              ? sbmq_pkg::MAX_OUT : it.frame_count;
                    end
                    else if (q == 64)
                    begin
                        port = sbmq_pkg::PORT_CRITICAL;
                        lim = 1;
                    end
                    while (n < lim && fill[q] != 0)
                    begin
                        held_bits = held_bits >= sz_mem[q][head[q]]
                                    ? held_bits - sz_mem[q][head[q]] : 0;
                        fill[q]--;
                        push_result(sbmq_pkg::KIND_PACKET, tag_mem[q][head[q]],
                                    sz_mem[q][head[q]], port, sbmq_pkg::ST_ACCEPTED, q,
                                    fill[q], it.now - arr_mem[q][head[q]]);
                        head[q] = (head[q] + 1) % DEPTH;
                        n++;
                    end
                end
                sbmq_pkg::OP_REPORT:
                begin
                    for (int i = 0; i < RPT_Q; i++)
                    begin
                        taken[i] = 0;
                        ages[i] = fill[32 + i] != 0 ? it.now - arr_mem[32 + i][head[32 + i]] : 0;
                    end
                    for (int i = 0; i < RPT_Q; i++)
                    begin
                        best = -1;
                        for (int j = 0; j < RPT_Q; j++)
                            if (!taken[j] && (best < 0 || ages[j] > ages[best]))
                                best = j;
                        taken[best] = 1;
                        push_result(sbmq_pkg::KIND_REPORT, 16'd0, 16'd0,
                                    sbmq_pkg::PORT_PERIODIC, sbmq_pkg::ST_ACCEPTED, 32 + best,
                                    fill[32 + best], ages[best]);
                    end
                    n = RPT_Q;
                end
                default:
                begin
                end
            endcase
            if (n > 0)
                pending[first + n - 1].last = 1'b1;
        endfunction

        function void check_result(sbmq_pkg::out_item_t got);
            sbmq_pkg::out_item_t exp;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch\n  exp %p\n  got %p", exp, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    sbmq_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    sbmq_pkg::out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [31:0] cfg_data;

    queue_scoreboard sb;
    int idle_cycles;
    bit no_gaps;
    bit done;

    shared_buffer_multi_queue_manager_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // output monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge clk)
        out_stall <= !no_gaps && $urandom_range(99) < 20;

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !done)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(sbmq_pkg::in_item_t it);
        while (!no_gaps && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_limit(logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.limit_bits = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic sbmq_pkg::in_item_t make_item(logic [1:0] op, int strm, int dst,
                                                     int sz, int tg, logic [31:0] t,
                                                     int sq, int fc);
        sbmq_pkg::in_item_t it;
        it.op = op;
        it.stream = strm[6:0];
        it.destination = dst[5:0];
        it.pkt_size = sz[15:0];
        it.pkt_tag = tg[15:0];
        it.now = t;
        it.subqueue = sq[6:0];
        it.frame_count = fc[6:0];
        return it;
    endfunction

    function automatic sbmq_pkg::in_item_t random_item(logic [31:0] t);
        sbmq_pkg::in_item_t it;
        int pick;
        it = make_item(sbmq_pkg::OP_ARRIVAL, 0, 0, 0, 0, t, 0, 0);
        it.pkt_tag = 16'($urandom);
        it.pkt_size = $urandom_range(99) < 70 ? 16'($urandom_range(4000)) : 16'($urandom);
        it.destination = $urandom_range(99) < 90 ? 6'($urandom_range(32, 1)) : 6'($urandom);
        it.stream = $urandom_range(99) < 92 ? 7'($urandom_range(65)) : 7'($urandom);
        it.subqueue = $urandom_range(99) < 90 ? 7'($urandom_range(64)) : 7'($urandom);
        it.frame_count = $urandom_range(99) < 90 ? 7'($urandom_range(8))
                                                 : 7'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 60)
            it.op = sbmq_pkg::OP_ARRIVAL;
        else if (pick < 92)
            it.op = sbmq_pkg::OP_DEQUEUE;
        else if (pick < 97)
            it.op = sbmq_pkg::OP_REPORT;
        else
            it.op = 2'd3;
        if ($urandom_range(99) < 5)
            it.now = $urandom;
        return it;
    endfunction

    initial
    begin
        logic [31:0] t;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        done = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        t = 32'd100;
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 1, 0, 65535, 16'hffff, t, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 32, 0, 0, 0, t + 1, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 0, 1, 100, 1, t + 2, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 64, 32, 200, 2, t + 3, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 33, 32, 300, 3, t + 4, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 65, 0, 400, 4, t + 5, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 66, 1, 5, 5, t, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 127, 63, 5, 5, t, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 40, 0, 5, 5, t, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 0, 33, 5, 5, t, 0, 0));
        send_item(make_item(sbmq_pkg::OP_REPORT, 0, 0, 0, 0, t + 10, 0, 0));
        send_item(make_item(2'd3, 0, 0, 0, 0, t, 0, 0));
        send_item(make_item(sbmq_pkg::OP_DEQUEUE, 0, 0, 0, 0, 32'hffffffff, 0, 0));
        send_item(make_item(sbmq_pkg::OP_DEQUEUE, 0, 0, 0, 0, t, 64, 1));
        send_item(make_item(sbmq_pkg::OP_DEQUEUE, 0, 0, 0, 0, t, 63, 0));
        send_item(make_item(sbmq_pkg::OP_DEQUEUE, 0, 0, 0, 0, t, 63, 127));
        send_item(make_item(sbmq_pkg::OP_DEQUEUE, 0, 0, 0, 0, t, 127, 1));
        send_item(make_item(sbmq_pkg::OP_DEQUEUE, 0, 0, 0, 0, t, 5, 1));
        // fill one queue past depth
        for (int i = 0; i < 66; i++)
            send_item(make_item(sbmq_pkg::OP_ARRIVAL, 0, 5, 1, i, t + i, 0, 0));
        send_item(make_item(sbmq_pkg::OP_DEQUEUE, 0, 0, 0, 0, t + 99, 36, 64));
        write_limit(32'd0);
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 2, 0, 1, 9, t, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 50, 3, 1, 9, t, 0, 0));
        send_item(make_item(sbmq_pkg::OP_ARRIVAL, 65, 0, 0, 9, t, 0, 0));
        write_limit(32'hffffffff);

        // random
        for (int n = 0; n < 500; n++)
        begin
            no_gaps = n >= 150 && n < 250;
            if (n == 200)
                drain_results();
            if (n == 300)
                write_limit(32'd20000);
            if (n == 400)
                write_limit($urandom);
            t = t + $urandom_range(50);
            send_item(random_item(t));
        end
        write_limit(32'd1048576);
        send_item(make_item(sbmq_pkg::OP_REPORT, 0, 0, 0, 0, t + 1, 0, 0));

        drain_results();
        done = 1'b1;
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
